[sv/bsqrt_pkg.sv]
// Shared types and constants for the bisection square root block.
`timescale 1ns / 1ps
`default_nettype none

package bsqrt_pkg;

    // Width of every Q20.24 value on the ports.
    localparam int DATA_W = 44;
    // Halves used to build the square from three narrow products.
    localparam int HALF_W = DATA_W / 2;
    // Full width of an exact square.
    localparam int SQ_W = 2 * DATA_W;
    // Width of the iteration count field.
    localparam int ITER_W = 6;
    // Width of the status field.
    localparam int STAT_W = 2;

    // Stream payload widths, padded up to whole bytes.
    localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 3 * DATA_W + ITER_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(1678);

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_TOL   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EXACT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_CHK   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

[sv/bisection_square_root_top.sv]
// Bisection square root over Q20.24 unsigned values with a shared squaring unit.
// v = 0 goes straight to the result; otherwise the block takes up to MAX_STEPS halving steps.
// Each halving step works through ST_MUL (three 22x22 partial products), ST_SUM (the
// square sum), then ST_CHK (the tolerance compare and interval update).
// One item is worked at a time.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n, asynchronous, active low) empties the block and sets tolerance to 1678.
`timescale 1ns / 1ps
`default_nettype none

module bisection_square_root_top #(
    parameter int MAX_STEPS     = 48,
    parameter int FRACTION_BITS = 24
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Tolerance register write.
    input  wire                                 tol_wr_en,
    input  wire  [bsqrt_pkg::DATA_W-1:0]        tol_wr_data,
    // Input stream.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [bsqrt_pkg::IN_TDATA_W-1:0]    s_tdata,   // [43:0] value
    // Result stream.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [43:0] root, [87:44] lower_bound, [131:88] upper_bound, [137:132] iterations
    output logic [bsqrt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [bsqrt_pkg::STAT_W-1:0]        m_tuser    // [1:0] status
);

    import bsqrt_pkg::*;

    localparam int CMP_W = SQ_W + 1;
    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRACTION_BITS;

    state_t state_reg, state_next;

    logic [DATA_W-1:0]     tol_reg;
    logic [DATA_W-1:0]     v_reg, v_next;
    logic [DATA_W-1:0]     a_reg, a_next;
    logic [DATA_W-1:0]     b_reg, b_next;
    logic [DATA_W-1:0]     x_reg, x_next;
    logic [ITER_W-1:0]     steps_reg, steps_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic                  chk_end_reg, chk_end_next;

    logic [SQ_W-1:0]       target_reg, target_next;
    logic [CMP_W-1:0]      hi_reg, hi_next;
    logic [CMP_W-1:0]      lo_reg, lo_next;

    logic [2*HALF_W-1:0]   p_ll_reg, p_lh_reg, p_hh_reg;
    logic [SQ_W-1:0]       sq_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  out_load;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STAT_W-1:0]     m_tuser_reg;

    logic [HALF_W-1:0]     x_lo, x_hi;
    logic [SQ_W-1:0]       sq_sum;
    logic [SQ_W-1:0]       limit_ext;
    logic                  in_tol;
    logic                  sq_below;
    logic [DATA_W:0]       mid_sum;
    logic [DATA_W-1:0]     upd_a, upd_b;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Shared squaring unit: x = x_hi * 2^22 + x_lo.
    assign x_lo   = x_reg[HALF_W-1:0];
    assign x_hi   = x_reg[DATA_W-1:HALF_W];
    assign sq_sum = (SQ_W'(p_hh_reg) << (2 * HALF_W))
                  + (SQ_W'(p_lh_reg) << (HALF_W + 1))
                  + SQ_W'(p_ll_reg);

    // |sq - target| <= limit is the same as lo <= sq <= hi; a borrow on lo means no floor.
    assign limit_ext = SQ_W'(tol_reg) << FRACTION_BITS;
    assign in_tol    = (lo_reg[CMP_W-1] || (sq_reg >= lo_reg[SQ_W-1:0]))
                    && (CMP_W'(sq_reg) <= hi_reg);
    assign sq_below  = (sq_reg < target_reg);

    assign upd_a   = sq_below ? x_reg : a_reg;
    assign upd_b   = sq_below ? b_reg : x_reg;
    assign mid_sum = {1'b0, upd_a} + {1'b0, upd_b};

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next   = state_reg;
        v_next       = v_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        x_next       = x_reg;
        steps_next   = steps_reg;
        status_next  = status_reg;
        chk_end_next = chk_end_reg;
        target_next  = target_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    v_next     = s_tdata[DATA_W-1:0];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                target_next  = SQ_W'(v_reg) << FRACTION_BITS;
                hi_next      = CMP_W'(SQ_W'(v_reg) << FRACTION_BITS) + CMP_W'(limit_ext);
                lo_next      = CMP_W'(SQ_W'(v_reg) << FRACTION_BITS) - CMP_W'(limit_ext);
                a_next       = '0;
                b_next       = (v_reg > ONE) ? v_reg : ONE;
                steps_next   = '0;
                chk_end_next = 1'b1;
                if (v_reg == '0)
                begin
                    // Zero is its own root: the lower endpoint matches.
                    x_next      = '0;
                    status_next = STAT_EXACT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    x_next     = (v_reg > ONE) ? v_reg : ONE;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (chk_end_reg)
                begin
                    // The first square is of the upper endpoint.
                    chk_end_next = 1'b0;
                    if (sq_reg == target_reg)
                    begin
                        status_next = STAT_EXACT;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        x_next     = DATA_W'(({1'b0, a_reg} + {1'b0, b_reg}) >> 1);
                        state_next = ST_MUL;
                    end
                end
                else if (in_tol)
                begin
                    status_next = STAT_TOL;
                    state_next  = ST_DONE;
                end
                else if (steps_reg >= ITER_W'(MAX_STEPS))
                begin
                    status_next = STAT_LIMIT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    a_next     = upd_a;
                    b_next     = upd_b;
                    x_next     = mid_sum[DATA_W:1];
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tol_reg      <= TOL_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (tol_wr_en)
            begin
                tol_reg <= tol_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        steps_reg   <= steps_next;
        status_reg  <= status_next;
        chk_end_reg <= chk_end_next;
        target_reg  <= target_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        p_ll_reg    <= x_lo * x_lo;
        p_lh_reg    <= x_lo * x_hi;
        p_hh_reg    <= x_hi * x_hi;
        sq_reg      <= sq_sum;
        if (out_load)
        begin
            m_tdata_reg <= OUT_TDATA_W'({steps_reg, b_reg, a_reg, x_reg});
            m_tuser_reg <= status_reg;
        end
    end

    // The interval never inverts and the probe stays inside it.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_SUM || state_reg == ST_CHK)
        |-> (a_reg <= b_reg && x_reg >= a_reg && x_reg <= b_reg))
        else $error("bisection interval out of order");

    a_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_EXACT) |-> (m_tdata[3*DATA_W +: ITER_W] == '0))
        else $error("exact endpoint reported with halving steps");

    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3*DATA_W +: ITER_W] <= ITER_W'(MAX_STEPS)))
        else $error("step count beyond limit");

    a_limit_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_LIMIT)
        |-> (m_tdata[3*DATA_W +: ITER_W] == ITER_W'(MAX_STEPS)))
        else $error("limit status without the full step count");

endmodule

`default_nettype wire
